>>> hdl/uartbd_pkg.sv
// Shared constants for the UART baud divisor calculator: field widths,
// status codes, register map and reset values. No dependencies.
`default_nettype none

package uartbd_pkg;

  localparam int CLK_W  = 30;
  localparam int LIM_W  = 7;
  localparam int BAUD_W = 25;
  localparam int STAT_W = 2;

  // Achieved baud never exceeds the reference clock over sixteen.
  localparam int ACH_W  = CLK_W - 4;
  localparam int PCT_W  = 7;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ERROR = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_CLOCK = 3'd0;
  localparam logic [ADDR_W-1:0] REG_LIMIT = 3'd4;

  localparam logic [CLK_W-1:0] CLK_RESET = 30'd24000000;
  localparam logic [LIM_W-1:0] LIM_RESET = 7'd3;

endpackage

`default_nettype wire

>>> hdl/uart_baud_divisor_calculator_core.sv
// Top level of the UART baud divisor calculator with its APB register port.
// Depends on uartbd_pkg and uartbd_div.
`default_nettype none

// Takes one requested baud rate per transfer and returns the integer and
// fractional divisor with a status. A new request is accepted every cycle;
// the whole pipeline holds while a result waits at the output. The stages
// are those of the two bit-per-stage dividers (divisor, then achieved baud)
// and four stages of rounding, error and compare. Registers: ref_clock_hz
// at 0x0, max_error_percent at 0x4; write them only while no request is
// in flight.
module uart_baud_divisor_calculator_core #(
  parameter int FRAC_BITS = 6,
  parameter int INT_BITS  = 16,
  localparam int OUT_BITS = INT_BITS + FRAC_BITS + uartbd_pkg::STAT_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [24:0] baud_rate, upper bits zero
  input  wire logic [31:0]                   in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // integer_divisor, fraction_divisor, status from bit 0 up, zero padded
  output logic [OUT_W-1:0]                   out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [uartbd_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  import uartbd_pkg::*;

  localparam int Q1_W  = CLK_W + FRAC_BITS + 1 - 4;
  localparam int IDV_W = Q1_W - FRAC_BITS - 1;
  localparam int DV_W  = INT_BITS + FRAC_BITS;
  localparam int S2_W  = BAUD_W + INT_BITS + FRAC_BITS + 1;
  localparam int E_W   = ACH_W + PCT_W;
  localparam int LB_W  = BAUD_W + LIM_W;

  // Configuration registers
  logic [CLK_W-1:0] clk_r;
  logic [LIM_W-1:0] lim_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r <= CLK_RESET;
      lim_r <= LIM_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_LIMIT[2]) begin
        lim_r <= cfg_pwdata[LIM_W-1:0];
      end else begin
        clk_r <= cfg_pwdata[CLK_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_LIMIT[2]) begin
      cfg_prdata = {{(32-LIM_W){1'b0}}, lim_r};
    end else begin
      cfg_prdata = {{(32-CLK_W){1'b0}}, clk_r};
    end
  end

  // Global advance: every stage moves when the output register can take data.
  logic out_valid_r;
  logic adv;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Divider one: clock * 2^(F+1) over sixteen times baud.
  logic [BAUD_W-1:0] in_baud;
  logic              d1_vld;
  logic [Q1_W-1:0]   d1_quo;
  logic [BAUD_W-1:0] d1_baud;

  assign in_baud = in_tdata[BAUD_W-1:0];

  uartbd_div #(
    .NW(CLK_W + FRAC_BITS + 1),
    .DW(BAUD_W + 4),
    .QW(Q1_W),
    .SW(BAUD_W)
  ) u_div_scaled (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .in_num   ({clk_r, {(FRAC_BITS + 1){1'b0}}}),
    .in_den   ({in_baud, 4'b0000}),
    .in_side  (in_baud),
    .out_valid(d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_baud)
  );

  // Rounding stage: split the quotient and fold any rounding carry upward.
  logic [IDV_W-1:0]     idv_full;
  logic [FRAC_BITS:0]   frac_sum;
  logic                 carry;
  logic                 bad_nxt;
  logic [INT_BITS-1:0]  idiv_nxt;
  logic [FRAC_BITS-1:0] frac_nxt;

  assign idv_full = d1_quo[Q1_W-1:FRAC_BITS+1];
  assign frac_sum = {1'b0, d1_quo[FRAC_BITS:1]} + {{FRAC_BITS{1'b0}}, d1_quo[0]};
  assign carry    = frac_sum[FRAC_BITS];
  assign idiv_nxt = idv_full[INT_BITS-1:0] + {{(INT_BITS-1){1'b0}}, carry};
  assign frac_nxt = carry ? '0 : frac_sum[FRAC_BITS-1:0];
  assign bad_nxt  = (d1_baud == '0) || (idv_full == '0)
                 || (idv_full[IDV_W-1:INT_BITS] != '0)
                 || (carry && (idv_full[INT_BITS-1:0] == '1));

  logic                 s1_vld_r;
  logic [BAUD_W-1:0]    s1_baud_r;
  logic [INT_BITS-1:0]  s1_idiv_r;
  logic [FRAC_BITS-1:0] s1_frac_r;
  logic                 s1_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_baud_r <= d1_baud;
      s1_idiv_r <= idiv_nxt;
      s1_frac_r <= frac_nxt;
      s1_bad_r  <= bad_nxt;
    end
  end

  // Divider two: achieved baud, clock * 2^F over sixteen times the divisor.
  logic              d2_vld;
  logic [ACH_W-1:0]  d2_ach;
  logic [S2_W-1:0]   d2_side;

  uartbd_div #(
    .NW(CLK_W + FRAC_BITS),
    .DW(DV_W + 4),
    .QW(ACH_W),
    .SW(S2_W)
  ) u_div_achieved (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s1_vld_r),
    .in_num   ({clk_r, {FRAC_BITS{1'b0}}}),
    .in_den   ({s1_idiv_r, s1_frac_r, 4'b0000}),
    .in_side  ({s1_bad_r, s1_frac_r, s1_idiv_r, s1_baud_r}),
    .out_valid(d2_vld),
    .out_quo  (d2_ach),
    .out_side (d2_side)
  );

  logic [BAUD_W-1:0] d2_baud;
  logic [ACH_W-1:0]  baud_ext;

  assign d2_baud  = d2_side[BAUD_W-1:0];
  assign baud_ext = {{(ACH_W-BAUD_W){1'b0}}, d2_baud};

  // Error stage: absolute difference between achieved and requested rate.
  logic              s2_vld_r;
  logic [ACH_W-1:0]  s2_err_r;
  logic [S2_W-1:0]   s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_err_r  <= (d2_ach >= baud_ext) ? (d2_ach - baud_ext) : (baud_ext - d2_ach);
      s2_side_r <= d2_side;
    end
  end

  // Scale stage: percent >= limit is the same as err*100 >= limit*baud.
  logic              s3_vld_r;
  logic [E_W-1:0]    s3_e100_r;
  logic [LB_W-1:0]   s3_lb_r;
  logic [S2_W-1:0]   s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_e100_r <= {{PCT_W{1'b0}}, s2_err_r} * {{ACH_W{1'b0}}, PCT_SCALE};
      s3_lb_r   <= {{LIM_W{1'b0}}, s2_side_r[BAUD_W-1:0]} * {{BAUD_W{1'b0}}, lim_r};
      s3_side_r <= s2_side_r;
    end
  end

  // Output register
  logic [INT_BITS-1:0]  s3_idiv;
  logic [FRAC_BITS-1:0] s3_frac;
  logic                 s3_bad;
  logic                 s3_over;
  logic [INT_BITS-1:0]  out_idiv_r;
  logic [FRAC_BITS-1:0] out_frac_r;
  logic [STAT_W-1:0]    out_stat_r;

  assign s3_idiv = s3_side_r[BAUD_W +: INT_BITS];
  assign s3_frac = s3_side_r[BAUD_W+INT_BITS +: FRAC_BITS];
  assign s3_bad  = s3_side_r[S2_W-1];
  assign s3_over = {{(E_W-LB_W){1'b0}}, s3_lb_r} <= s3_e100_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idiv_r <= s3_bad ? '0 : s3_idiv;
      out_frac_r <= s3_bad ? '0 : s3_frac;
      out_stat_r <= s3_bad ? STATUS_RANGE : (s3_over ? STATUS_ERROR : STATUS_OK);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_stat_r, out_frac_r, out_idiv_r};

  // A range failure always reports a cleared divisor.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r == STATUS_RANGE) |-> (out_idiv_r == '0) && (out_frac_r == '0))
    else $error("range status with nonzero divisor");

  // A good divisor is never zero.
  a_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r != STATUS_RANGE) |-> (out_idiv_r != '0))
    else $error("zero divisor reported as valid");

  // A stalled result stays put, and the stages behind it with it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(out_stat_r) && $stable(s3_vld_r))
    else $error("pipeline moved during stall");

  // A write to the limit register lands in the next cycle.
  a_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (cfg_paddr[2] == REG_LIMIT[2]) |=> lim_r == $past(cfg_pwdata[LIM_W-1:0]))
    else $error("limit register write lost");

endmodule

`default_nettype wire

>>> hdl/uartbd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside each transfer; depends on nothing.
`default_nettype none

module uartbd_div #(
  parameter int NW = 37,
  parameter int DW = 29,
  parameter int QW = 33,
  parameter int SW = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic          vld_r  [QW+1];
  logic [NW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  assign vld_r[0]  = in_valid;
  assign rem_r[0]  = in_num;
  assign den_r[0]  = in_den;
  assign quo_r[0]  = '0;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int SH = QW - 1 - i;
    logic [NW+DW-1:0] trial;
    logic             ge;
    logic [NW-1:0]    rem_nxt;

    assign trial   = {{NW{1'b0}}, den_r[i]} << SH;
    assign ge      = {{DW{1'b0}}, rem_r[i]} >= trial;
    assign rem_nxt = ge ? (rem_r[i] - trial[NW-1:0]) : rem_r[i];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        den_r[i+1]  <= den_r[i];
        quo_r[i+1]  <= {quo_r[i][QW-2:0], ge};
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_side  = side_r[QW];

endmodule

`default_nettype wire

>>> test/uartbd_checker.sv
// Checker for the UART baud divisor calculator: watches the request and result
// transfers, predicts each result and compares it. Depends on uartbd_pkg.
`timescale 1ns / 100ps
`default_nettype none

module uartbd_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output int               fail_count,
  output int               pending
);
  import uartbd_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  frac;
    logic [15:0] idiv;
  } divisor_t;

  logic [CLK_W-1:0] clock_hz;
  logic [LIM_W-1:0] limit_pct;
  divisor_t divisors_due[$];

  function automatic divisor_t calc_divisor(logic [BAUD_W-1:0] baud);
    logic [63:0] idiv, scaled, frac, dv, ach, err, pct;
    divisor_t r;
    r = '0;
    r.status = STATUS_RANGE;
    if (baud == 0) return r;
    idiv = 64'(clock_hz) / 16 / baud;
    if (idiv < 1 || idiv > 65535) return r;
    scaled = (64'(clock_hz) << 7) / 16 / baud;
    frac = ((scaled >> 1) & 63) + (scaled & 1);
    if (frac >= 64) begin
      frac = 0;
      idiv = idiv + 1;
      if (idiv > 65535) return r;
    end
    dv = (idiv << 6) + frac;
    ach = (64'(clock_hz) << 6) / 16 / dv;
    err = (ach >= baud) ? ach - baud : baud - ach;
    pct = err * 100 / baud;
    r.idiv = idiv[15:0];
    r.frac = frac[5:0];
    r.status = (pct >= limit_pct) ? STATUS_ERROR : STATUS_OK;
    return r;
  endfunction

  assign pending = divisors_due.size();

  always @(posedge clk) begin
    divisor_t got, want;
    if (!rst_n) begin
      clock_hz <= CLK_RESET;
      limit_pct <= LIM_RESET;
      fail_count <= 0;
      divisors_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr == REG_CLOCK) clock_hz <= cfg_pwdata[CLK_W-1:0];
        else if (cfg_paddr == REG_LIMIT) limit_pct <= cfg_pwdata[LIM_W-1:0];
      end
      if (in_tvalid && in_tready)
        divisors_due.push_back(calc_divisor(in_tdata[BAUD_W-1:0]));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (divisors_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = divisors_due.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: int %0d/%0d frac %0d/%0d status %0d/%0d (exp/act)",
                       want.idiv, got.idiv, want.frac, got.frac, want.status, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench top for the UART baud divisor calculator: clock, reset, stimulus,
// register writes and verdict. Depends on uartbd_pkg and uartbd_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import uartbd_pkg::*;

  localparam int LATENCY = 70;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [31:0] in_tdata = 0;
  logic in_tready, out_tvalid;
  logic [23:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  logic cfg_pready;
  int fail_count, pending, idle_cycles;
  bit long_hold = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  uart_baud_divisor_calculator_core u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready);

  uartbd_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending);

  // Receiver stall pattern, with one long hold-off on request.
  always @(negedge clk) begin
    int k;
    if (long_hold) begin
      out_tready <= 0;
      for (k = 0; k < 150; k++) @(negedge clk);
      long_hold = 0;
    end else begin
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b0;
        default: out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL uart_baud_divisor_calculator_core");
      $finish;
    end
  end

  task automatic send_baud(logic [24:0] baud);
    in_tvalid <= 1;
    in_tdata <= {7'd0, baud};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic [24:0] rand_baud();
    case ($urandom_range(0, 4))
      0: return 25'($urandom);
      1: return 25'($urandom_range(0, 300));
      2: return 25'($urandom_range(1, 200000));
      default: return 25'($urandom_range(300, 4000000));
    endcase
  endfunction

  initial begin
    logic [31:0] clocks[5];
    logic [31:0] limits[5];
    int p, i;
    clocks = '{24000000, 1, 32'h3FFFFFFF, 1843200, 48000000};
    limits = '{3, 0, 100, 1, 5};
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: zero, ones, extremes, rounding carry region, out of range.
    send_baud(0); send_baud(1); send_baud(25'h1FFFFFF); send_baud(115200);
    send_baud(9600); send_baud(1500000); send_baud(1499999); send_baud(22);
    send_baud(23); send_baud(1000000); send_baud(3000000); send_baud(250000);
    send_baud(25'h1555555); send_baud(25'h0AAAAAA); send_baud(7);
    drain();
    for (p = 0; p < 5; p++) begin
      write_reg(REG_CLOCK, clocks[p]);
      write_reg(REG_LIMIT, limits[p]);
      if (p == 1) long_hold = 1;
      for (i = 0; i < 170; i++) send_baud(rand_baud());
      drain();
    end
    write_reg(REG_CLOCK, 32'hFFFFFFFF);
    write_reg(REG_LIMIT, 32'hFFFFFF80);
    for (i = 0; i < 20; i++) send_baud(rand_baud());
    drain();
    if (fail_count == 0) $display("PASS uart_baud_divisor_calculator_core");
    else $display("FAIL uart_baud_divisor_calculator_core");
    $finish;
  end
endmodule

`default_nettype wire
